>>> design/cst_pkg.sv
package cst_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // one classified request as it travels from the front to the back
    typedef struct packed {
        logic       func;       // end of stream
        logic [7:0] ch;
        logic       alpha;
        logic       word;       // letter, digit or underscore
        logic       ws3;        // space, tab, newline
        logic       ws4;        // ws3 plus carriage return
        logic       arg_start;
        logic       unq_plain;  // plain symbol or letter or digit
        logic       hash;
        logic       quote;
        logic       lpar;
        logic       rpar;
        logic       bslash;
        logic       nl;
    } cst_item_t;

endpackage

>>> design/command_script_tokenizer.sv
// command script tokenizer
// takes one script byte per request on the s_ channel (s_tuser low) or an
// end-of-stream marker (s_tuser high), and returns exactly one result per
// request on the m_ channel, in order
// each byte is tagged with its token class, a start flag, a content flag,
// the unquoted parenthesis depth and an error code; the end result carries
// m_tlast, reports the latched or end-of-stream error code and clears the
// tokenizer state
// after an error every byte reports code 8 until the end marker
// a request is written into the queue, then lexed from the queue head into the
// output register; throughput is one request per cycle while the receiver
// accepts results, set by the lexer state update in the back end
// a four-entry queue sits between the byte classifier and the lexer, and
// the lexer result is held in an output register, so a stalled receiver
// first fills the queue and s_tready drops only when it is full
// reset empties the queue, drops m_tvalid and puts the lexer at top level
module command_script_tokenizer #(
    parameter int NEST_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // token_kind, token_start, is_content, paren_depth,
                                   // error_code, zero padding
    output logic        m_tlast    // stream_done
);

    cst_pkg::cst_item_t in_item;
    cst_pkg::cst_item_t head_item;
    logic               push;
    logic               full;
    logic               not_empty;
    logic               pop;

    cst_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (full),
        .push       (push),
        .item       (in_item)
    );

    cst_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (in_item),
        .full       (full),
        .not_empty  (not_empty),
        .pop        (pop),
        .head_item  (head_item)
    );

    cst_back #(
        .NEST_BITS (NEST_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (not_empty),
        .item       (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> design/cst_front.sv
module cst_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  logic               queue_full,
    output logic               push,
    output cst_pkg::cst_item_t item
);

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    logic [7:0] c;
    logic       alpha;
    logic       digit;
    logic       sym_common;

    assign c     = s_tdata;
    assign alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    assign digit = (c >= 8'h30 && c <= 8'h39);

    // symbols that both start an unquoted argument and continue one
    assign sym_common = (c == 8'h3C) || (c == 8'h3E) || (c == 8'h2A) || (c == CH_UNDER) ||
                        (c == 8'h2D) || (c == 8'h2E) || (c == 8'h5B) || (c == 8'h40) ||
                        (c == 8'h24) || (c == 8'h2F);

    always_comb begin
        item.func      = s_tuser;
        item.ch        = c;
        item.alpha     = alpha;
        item.word      = alpha || digit || (c == CH_UNDER);
        item.ws3       = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
        item.ws4       = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
        item.arg_start = alpha || digit || sym_common || (c == CH_LPAR) || (c == CH_BSLASH);
        item.unq_plain = alpha || digit || sym_common || (c == 8'h7B) || (c == 8'h7D) ||
                         (c == 8'h3A) || (c == 8'h3D) || (c == 8'h5D) || (c == 8'h2B);
        item.hash      = (c == CH_HASH);
        item.quote     = (c == CH_QUOTE);
        item.lpar      = (c == CH_LPAR);
        item.rpar      = (c == CH_RPAR);
        item.bslash    = (c == CH_BSLASH);
        item.nl        = (c == CH_NL);
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

endmodule

>>> design/cst_queue.sv
module cst_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cst_pkg::cst_item_t push_item,
    output logic               full,
    output logic               not_empty,
    input  logic               pop,
    output cst_pkg::cst_item_t head_item
);

    cst_pkg::cst_item_t                  entry_reg [cst_pkg::QUEUE_DEPTH];
    logic [cst_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [cst_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [cst_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [cst_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [cst_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic [cst_pkg::QUEUE_CNT_W-1:0]     count_next;

    assign full      = (count_reg == cst_pkg::QUEUE_CNT_W'(cst_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/cst_back.sv
module cst_back #(
    parameter int NEST_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  cst_pkg::cst_item_t item,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic               m_tlast
);

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_SPACE  = 3'd1;
    localparam logic [2:0] KIND_CMT    = 3'd2;
    localparam logic [2:0] KIND_NAME   = 3'd3;
    localparam logic [2:0] KIND_QUOTED = 3'd4;
    localparam logic [2:0] KIND_UNQ    = 3'd5;
    localparam logic [2:0] KIND_OPEN   = 3'd6;
    localparam logic [2:0] KIND_CLOSE  = 3'd7;

    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_TOP      = 4'd1;
    localparam logic [3:0] ERR_END_NAME = 4'd2;
    localparam logic [3:0] ERR_PRE      = 4'd3;
    localparam logic [3:0] ERR_ARGS     = 4'd4;
    localparam logic [3:0] ERR_END_ESC  = 4'd5;
    localparam logic [3:0] ERR_END_UNQ  = 4'd6;
    localparam logic [3:0] ERR_NEST     = 4'd7;
    localparam logic [3:0] ERR_IGNORED  = 4'd8;

    typedef enum logic [3:0] {
        M_TOP      = 4'd0,
        M_TOP_WS   = 4'd1,
        M_TOP_CMT  = 4'd2,
        M_NAME     = 4'd3,
        M_PRE      = 4'd4,
        M_PRE_WS   = 4'd5,
        M_ARGS     = 4'd6,
        M_ARG_WS   = 4'd7,
        M_ARG_CMT  = 4'd8,
        M_QUOTED   = 4'd9,
        M_UNQ      = 4'd10
    } mode_t;

    typedef struct packed {
        logic                 used;
        logic                 ovf;
        logic                 esc;
        logic                 iq;
        logic [NEST_BITS-1:0] nest;
    } unq_t;

    // one byte of an unquoted argument
    function automatic unq_t unq_step(cst_pkg::cst_item_t it, logic e, logic q,
                                      logic [NEST_BITS-1:0] n);
        unq_t r;
        r.used = 1'b1;
        r.ovf  = 1'b0;
        r.esc  = e;
        r.iq   = q;
        r.nest = n;
        if (e) begin
            r.esc = 1'b0;
        end else if (it.quote) begin
            r.iq = ~q;
        end else if (it.bslash) begin
            r.esc = 1'b1;
        end else if (it.lpar) begin
            if (!q) begin
                if (&n) begin
                    r.ovf = 1'b1;
                end else begin
                    r.nest = n + 1'b1;
                end
            end
        end else if (it.rpar) begin
            if (!q) begin
                if (n == '0) begin
                    r.used = 1'b0;
                end else begin
                    r.nest = n - 1'b1;
                end
            end
        end else if (!it.unq_plain) begin
            r.used = 1'b0;
        end
        return r;
    endfunction

    mode_t                mode_reg, mode_next, eff_mode;
    logic [7:0]           run_reg, run_next;
    logic                 esc_reg, esc_next;
    logic                 iq_reg, iq_next;
    logic [NEST_BITS-1:0] nest_reg, nest_next;
    logic [3:0]           err_reg, err_next;

    logic                 m_tvalid_reg;
    logic [2:0]           kind_reg, kind_next;
    logic                 start_reg, start_next;
    logic                 content_reg, content_next;
    logic [7:0]           depth_reg, depth_next;
    logic [3:0]           code_reg, code_next;
    logic                 done_reg, done_next;

    unq_t                 u_cur;
    unq_t                 u_new;
    logic [NEST_BITS+7:0] nest_wide;

    assign pop = item_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        mode_next    = mode_reg;
        run_next     = run_reg;
        esc_next     = esc_reg;
        iq_next      = iq_reg;
        nest_next    = nest_reg;
        err_next     = err_reg;
        kind_next    = KIND_NONE;
        start_next   = 1'b0;
        content_next = 1'b0;
        code_next    = ERR_OK;
        done_next    = 1'b0;
        eff_mode     = mode_reg;
        u_cur        = unq_step(item, esc_reg, iq_reg, nest_reg);
        u_new        = unq_step(item, 1'b0, 1'b0, '0);

        if (item.func) begin
            done_next = 1'b1;
            if (err_reg != ERR_OK) begin
                code_next = err_reg;
            end else if (mode_reg == M_NAME) begin
                code_next = ERR_END_NAME;
            end else if (mode_reg == M_QUOTED && esc_reg) begin
                code_next = ERR_END_ESC;
            end else if (mode_reg == M_UNQ) begin
                code_next = ERR_END_UNQ;
            end
            mode_next = M_TOP;
            run_next  = '0;
            esc_next  = 1'b0;
            iq_next   = 1'b0;
            nest_next = '0;
            err_next  = ERR_OK;
        end else if (err_reg != ERR_OK) begin
            code_next = ERR_IGNORED;
        end else begin
            // first resolve the mode that actually takes this byte
            case (mode_reg)
                M_TOP_WS: if (item.ch != run_reg) eff_mode = M_TOP;
                M_PRE_WS: if (item.ch != run_reg) eff_mode = M_PRE;
                M_ARG_WS: if (item.ch != run_reg) eff_mode = M_ARGS;
                M_NAME:   if (!item.word) eff_mode = M_PRE;
                M_UNQ:    if (!u_cur.used) eff_mode = M_ARGS;
                default:  eff_mode = mode_reg;
            endcase
            mode_next = eff_mode;

            case (eff_mode)
                M_TOP_WS, M_PRE_WS, M_ARG_WS: begin
                    kind_next    = KIND_SPACE;
                    content_next = 1'b1;
                end
                M_TOP_CMT, M_ARG_CMT: begin
                    kind_next = KIND_CMT;
                    if (item.nl) begin
                        mode_next = (eff_mode == M_TOP_CMT) ? M_TOP : M_ARGS;
                    end else begin
                        content_next = 1'b1;
                    end
                end
                M_NAME: begin
                    kind_next    = KIND_NAME;
                    content_next = 1'b1;
                end
                M_QUOTED: begin
                    kind_next = KIND_QUOTED;
                    if (item.quote && !esc_reg) begin
                        mode_next = M_ARGS;
                    end else begin
                        content_next = 1'b1;
                        esc_next     = item.bslash && !esc_reg;
                    end
                end
                M_UNQ: begin
                    if (u_cur.ovf) begin
                        err_next  = ERR_NEST;
                        code_next = ERR_NEST;
                    end else begin
                        esc_next     = u_cur.esc;
                        iq_next      = u_cur.iq;
                        nest_next    = u_cur.nest;
                        kind_next    = KIND_UNQ;
                        content_next = 1'b1;
                    end
                end
                M_PRE: begin
                    if (item.lpar) begin
                        kind_next  = KIND_OPEN;
                        start_next = 1'b1;
                        mode_next  = M_ARGS;
                    end else if (item.ws3) begin
                        mode_next    = M_PRE_WS;
                        run_next     = item.ch;
                        kind_next    = KIND_SPACE;
                        start_next   = 1'b1;
                        content_next = 1'b1;
                    end else begin
                        err_next  = ERR_PRE;
                        code_next = ERR_PRE;
                    end
                end
                M_ARGS: begin
                    if (item.rpar) begin
                        kind_next  = KIND_CLOSE;
                        start_next = 1'b1;
                        mode_next  = M_TOP;
                    end else if (item.ws3) begin
                        mode_next    = M_ARG_WS;
                        run_next     = item.ch;
                        kind_next    = KIND_SPACE;
                        start_next   = 1'b1;
                        content_next = 1'b1;
                    end else if (item.hash) begin
                        kind_next  = KIND_CMT;
                        start_next = 1'b1;
                        mode_next  = M_ARG_CMT;
                    end else begin
                        esc_next = 1'b0;
                        iq_next  = 1'b0;
                        if (item.quote) begin
                            kind_next  = KIND_QUOTED;
                            start_next = 1'b1;
                            mode_next  = M_QUOTED;
                        end else if (item.arg_start) begin
                            // a fresh argument starts from cleared flags and depth
                            mode_next    = M_UNQ;
                            esc_next     = u_new.esc;
                            iq_next      = u_new.iq;
                            nest_next    = u_new.nest;
                            kind_next    = KIND_UNQ;
                            start_next   = 1'b1;
                            content_next = 1'b1;
                        end else begin
                            err_next  = ERR_ARGS;
                            code_next = ERR_ARGS;
                        end
                    end
                end
                default: begin
                    mode_next = M_TOP;
                    if (item.ws4) begin
                        mode_next    = M_TOP_WS;
                        run_next     = item.ch;
                        kind_next    = KIND_SPACE;
                        start_next   = 1'b1;
                        content_next = 1'b1;
                    end else if (item.hash) begin
                        kind_next  = KIND_CMT;
                        start_next = 1'b1;
                        mode_next  = M_TOP_CMT;
                    end else if (item.alpha) begin
                        kind_next    = KIND_NAME;
                        start_next   = 1'b1;
                        content_next = 1'b1;
                        mode_next    = M_NAME;
                    end else begin
                        err_next  = ERR_TOP;
                        code_next = ERR_TOP;
                    end
                end
            endcase
        end

        // depth is reported saturated to eight bits
        nest_wide  = {8'd0, nest_next};
        depth_next = (nest_wide > (NEST_BITS + 8)'(255)) ? 8'hFF : nest_wide[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= M_TOP;
            run_reg      <= '0;
            esc_reg      <= 1'b0;
            iq_reg       <= 1'b0;
            nest_reg     <= '0;
            err_reg      <= ERR_OK;
            m_tvalid_reg <= 1'b0;
            kind_reg     <= KIND_NONE;
            start_reg    <= 1'b0;
            content_reg  <= 1'b0;
            depth_reg    <= '0;
            code_reg     <= ERR_OK;
            done_reg     <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg     <= mode_next;
                run_reg      <= run_next;
                esc_reg      <= esc_next;
                iq_reg       <= iq_next;
                nest_reg     <= nest_next;
                err_reg      <= err_next;
                m_tvalid_reg <= 1'b1;
                kind_reg     <= kind_next;
                start_reg    <= start_next;
                content_reg  <= content_next;
                depth_reg    <= depth_next;
                code_reg     <= code_next;
                done_reg     <= done_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, code_reg, depth_reg, content_reg, start_reg, kind_reg};
    assign m_tlast  = done_reg;

endmodule

>>> tb/tb_command_script_tokenizer.sv
module tb_command_script_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NEST_BITS    = 8;
    localparam int NEST_MAX     = (1 << NEST_BITS) - 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 240;
    localparam int HOLD_AT      = 80;
    localparam int HOLD_CYCLES  = 60;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [2:0] {
        TK_NONE     = 3'd0,
        TK_SPACE    = 3'd1,
        TK_COMMENT  = 3'd2,
        TK_NAME     = 3'd3,
        TK_QUOTED   = 3'd4,
        TK_UNQUOTED = 3'd5,
        TK_OPEN     = 3'd6,
        TK_CLOSE    = 3'd7
    } tok_kind_e;

    typedef enum logic [3:0] {
        ERR_OK             = 4'd0,
        ERR_TOP_BYTE       = 4'd1,
        ERR_END_AFTER_NAME = 4'd2,
        ERR_PRE_BYTE       = 4'd3,
        ERR_ARG_BYTE       = 4'd4,
        ERR_END_ESCAPE     = 4'd5,
        ERR_END_UNQUOTED   = 4'd6,
        ERR_NEST_OVERFLOW  = 4'd7,
        ERR_IGNORED        = 4'd8
    } tok_err_e;

    typedef enum logic [3:0] {
        LX_TOP, LX_TOP_WS, LX_TOP_CMT, LX_NAME, LX_PRE, LX_PRE_WS,
        LX_ARGS, LX_ARG_WS, LX_ARG_CMT, LX_QUOTED, LX_UNQ
    } lex_mode_e;

    localparam logic FN_BYTE = 1'b0;
    localparam logic FN_END  = 1'b1;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef struct {
        logic       func;
        logic [7:0] ch;
    } script_req_t;

    typedef struct {
        tok_kind_e  kind;
        logic       start;
        logic       content;
        logic [7:0] depth;
        tok_err_e   err;
        logic       done;
    } byte_tag_t;

    class tag_tracker;
        lex_mode_e   mode;
        logic [7:0]  run_ch;
        bit          esc;
        bit          inq;
        int          nest;
        tok_err_e    latched;
        byte_tag_t   cur;
        byte_tag_t   pending_tags[$];
        int          mismatches;
        int          checked;
        bit [15:0]   codes_seen;

        function new();
            clear();
            mismatches = 0;
            checked    = 0;
            codes_seen = '0;
        endfunction

        function void clear();
            mode    = LX_TOP;
            run_ch  = 8'h00;
            esc     = 1'b0;
            inq     = 1'b0;
            nest    = 0;
            latched = ERR_OK;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit is_alnum(logic [7:0] c);
            return is_alpha(c) || (c >= "0" && c <= "9");
        endfunction

        function bit is_ws3(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF;
        endfunction

        function bit is_arg_start(logic [7:0] c);
            return is_alnum(c) || c == "<" || c == ">" || c == "*" || c == CH_USCORE ||
                   c == "-" || c == CH_LPAR || c == "." || c == "[" || c == "@" ||
                   c == "$" || c == "/" || c == CH_BSLASH;
        endfunction

        function bit is_plain_sym(logic [7:0] c);
            return c == "$" || c == "{" || c == "}" || c == "-" || c == CH_USCORE ||
                   c == "." || c == "/" || c == "*" || c == "@" || c == ":" ||
                   c == "=" || c == "[" || c == "]" || c == "+" || c == "<" || c == ">";
        endfunction

        function void fail(tok_err_e code);
            latched     = code;
            cur.kind    = TK_NONE;
            cur.start   = 1'b0;
            cur.content = 1'b0;
            cur.err     = code;
        endfunction

        function void begin_ws(lex_mode_e m, logic [7:0] c);
            mode        = m;
            run_ch      = c;
            cur.kind    = TK_SPACE;
            cur.start   = 1'b1;
            cur.content = 1'b1;
        endfunction

        // returns 0 when the byte ends the unquoted argument without being used
        function bit unq_byte(logic [7:0] c, bit first);
            if (esc) begin
                esc = 1'b0;
            end else if (c == CH_QUOTE) begin
                inq = !inq;
            end else if (c == CH_BSLASH) begin
                esc = 1'b1;
            end else if (c == CH_LPAR) begin
                if (!inq) begin
                    if (nest >= NEST_MAX) begin
                        fail(ERR_NEST_OVERFLOW);
                        return 1'b1;
                    end
                    nest++;
                end
            end else if (c == CH_RPAR) begin
                if (!inq) begin
                    if (nest == 0)
                        return 1'b0;
                    nest--;
                end
            end else if (!is_plain_sym(c) && !is_alnum(c)) begin
                return 1'b0;
            end
            cur.kind    = TK_UNQUOTED;
            cur.start   = first;
            cur.content = 1'b1;
            return 1'b1;
        endfunction

        function void lex_byte(logic [7:0] c);
            bit again;
            cur.kind    = TK_NONE;
            cur.start   = 1'b0;
            cur.content = 1'b0;
            cur.err     = ERR_OK;
            cur.done    = 1'b0;
            if (latched != ERR_OK) begin
                cur.err = ERR_IGNORED;
                return;
            end
            do begin
                again = 1'b0;
                case (mode)
                    LX_TOP_WS, LX_PRE_WS, LX_ARG_WS: begin
                        if (c == run_ch) begin
                            cur.kind    = TK_SPACE;
                            cur.content = 1'b1;
                        end else begin
                            if (mode == LX_TOP_WS)
                                mode = LX_TOP;
                            else if (mode == LX_PRE_WS)
                                mode = LX_PRE;
                            else
                                mode = LX_ARGS;
                            again = 1'b1;
                        end
                    end
                    LX_TOP_CMT, LX_ARG_CMT: begin
                        cur.kind = TK_COMMENT;
                        if (c == CH_LF) begin
                            if (mode == LX_TOP_CMT)
                                mode = LX_TOP;
                            else
                                mode = LX_ARGS;
                        end else begin
                            cur.content = 1'b1;
                        end
                    end
                    LX_NAME: begin
                        if (is_alnum(c) || c == CH_USCORE) begin
                            cur.kind    = TK_NAME;
                            cur.content = 1'b1;
                        end else begin
                            mode  = LX_PRE;
                            again = 1'b1;
                        end
                    end
                    LX_QUOTED: begin
                        cur.kind = TK_QUOTED;
                        if (c == CH_QUOTE && !esc) begin
                            mode = LX_ARGS;
                        end else begin
                            cur.content = 1'b1;
                            esc = (c == CH_BSLASH) && !esc;
                        end
                    end
                    LX_UNQ: begin
                        if (!unq_byte(c, 1'b0)) begin
                            mode  = LX_ARGS;
                            again = 1'b1;
                        end
                    end
                    LX_PRE: begin
                        if (c == CH_LPAR) begin
                            cur.kind  = TK_OPEN;
                            cur.start = 1'b1;
                            mode      = LX_ARGS;
                        end else if (is_ws3(c)) begin
                            begin_ws(LX_PRE_WS, c);
                        end else begin
                            fail(ERR_PRE_BYTE);
                        end
                    end
                    LX_ARGS: begin
                        if (c == CH_RPAR) begin
                            cur.kind  = TK_CLOSE;
                            cur.start = 1'b1;
                            mode      = LX_TOP;
                        end else if (is_ws3(c)) begin
                            begin_ws(LX_ARG_WS, c);
                        end else if (c == CH_HASH) begin
                            cur.kind  = TK_COMMENT;
                            cur.start = 1'b1;
                            mode      = LX_ARG_CMT;
                        end else begin
                            esc = 1'b0;
                            inq = 1'b0;
                            if (c == CH_QUOTE) begin
                                cur.kind  = TK_QUOTED;
                                cur.start = 1'b1;
                                mode      = LX_QUOTED;
                            end else if (is_arg_start(c)) begin
                                nest = 0;
                                mode = LX_UNQ;
                                void'(unq_byte(c, 1'b1));
                            end else begin
                                fail(ERR_ARG_BYTE);
                            end
                        end
                    end
                    default: begin
                        mode = LX_TOP;
                        if (is_ws3(c) || c == CH_CR) begin
                            begin_ws(LX_TOP_WS, c);
                        end else if (c == CH_HASH) begin
                            cur.kind  = TK_COMMENT;
                            cur.start = 1'b1;
                            mode      = LX_TOP_CMT;
                        end else if (is_alpha(c)) begin
                            cur.kind    = TK_NAME;
                            cur.start   = 1'b1;
                            cur.content = 1'b1;
                            mode        = LX_NAME;
                        end else begin
                            fail(ERR_TOP_BYTE);
                        end
                    end
                endcase
            end while (again);
        endfunction

        function byte_tag_t predict(logic func, logic [7:0] ch);
            tok_err_e code;
            if (func == FN_END) begin
                code = latched;
                if (code == ERR_OK) begin
                    if (mode == LX_NAME)
                        code = ERR_END_AFTER_NAME;
                    else if (mode == LX_QUOTED && esc)
                        code = ERR_END_ESCAPE;
                    else if (mode == LX_UNQ)
                        code = ERR_END_UNQUOTED;
                end
                clear();
                cur.kind    = TK_NONE;
                cur.start   = 1'b0;
                cur.content = 1'b0;
                cur.err     = code;
                cur.done    = 1'b1;
            end else begin
                lex_byte(ch);
            end
            cur.depth = (nest > 255) ? 8'd255 : 8'(nest);
            return cur;
        endfunction

        function void note_request(logic func, logic [7:0] ch);
            pending_tags.insert(pending_tags.size(), predict(func, ch));
        endfunction

        function void check_result(logic [23:0] data, logic last);
            byte_tag_t want;
            bit        bad;
            checked++;
            if (pending_tags.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing expected: tdata %h tlast %b", data, last);
                return;
            end
            want = pending_tags.pop_front();
            codes_seen[int'(want.err)] = 1'b1;
            bad = (data[2:0] !== want.kind) || (data[3] !== want.start) ||
                  (data[4] !== want.content) || (data[12:5] !== want.depth) ||
                  (data[16:13] !== want.err) || (last !== want.done);
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result %0d exp kind %0d st %0d cont %0d depth %0d code %0d done %0d",
                             checked, want.kind, want.start, want.content, want.depth,
                             want.err, want.done);
                    $display("result %0d got kind %0d st %0d cont %0d depth %0d code %0d done %0d",
                             checked, data[2:0], data[3], data[4], data[12:5], data[16:13], last);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    tag_tracker  tracker;
    tag_tracker  gen_model;
    script_req_t script_q[$];
    int          live_count;
    int          sent_count;
    int          end_count;
    int          cycle_count;
    int          rx_cycle;
    int          rx_mode;
    int          hold_left;
    bit          hold_done;
    bit          rx_hold;

    command_script_tokenizer #(
        .NEST_BITS(NEST_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: a randomly redrawn stall pattern, plus one long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tlast);
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && tracker.checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 7);
                2:       m_tready <= (rx_cycle % 3 == 0);
                default: m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
        rx_hold = (hold_left > 0);
    end

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void put_req(logic func, logic [7:0] ch);
        script_req_t r;
        byte_tag_t   t;
        r.func = func;
        r.ch   = ch;
        script_q.insert(script_q.size(), r);
        // bytes swallowed after an error do not count as real stimulus
        t = gen_model.predict(func, ch);
        if (t.err != ERR_IGNORED)
            live_count++;
    endfunction

    function automatic void put_byte(logic [7:0] ch);
        put_req(FN_BYTE, ch);
    endfunction

    function automatic void put_end();
        put_req(FN_END, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_ws(bit with_cr);
        logic [7:0] c;
        case ($urandom_range(0, with_cr ? 3 : 2))
            0:       c = CH_SPACE;
            1:       c = CH_TAB;
            2:       c = CH_LF;
            default: c = CH_CR;
        endcase
        repeat ($urandom_range(1, 3)) put_byte(c);
    endfunction

    function automatic void put_name();
        put_byte(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        repeat ($urandom_range(0, 5))
            put_byte(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_"));
    endfunction

    function automatic void put_comment();
        logic [7:0] c;
        put_byte(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_LF)
                c = CH_SPACE;
            put_byte(c);
        end
        put_byte(CH_LF);
    endfunction

    function automatic void put_quoted();
        logic [7:0] c;
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
                put_byte(CH_BSLASH);
                put_byte(8'($urandom_range(0, 255)));
            end else begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE || c == CH_BSLASH)
                    c = "x";
                put_byte(c);
            end
        end
        put_byte(CH_QUOTE);
    endfunction

    function automatic void put_unquoted();
        int depth;
        bit inq;
        depth = 0;
        inq   = 1'b0;
        case ($urandom_range(0, 5))
            0: begin
                put_byte(CH_LPAR);
                depth = 1;
            end
            1: begin
                put_byte(CH_BSLASH);
                put_byte(8'($urandom_range(0, 255)));
            end
            default: put_byte(pick("abzAZ09<>*_-.[@$/"));
        endcase
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
                0: begin
                    put_byte(CH_BSLASH);
                    put_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    put_byte(CH_QUOTE);
                    inq = !inq;
                end
                2: begin
                    put_byte(CH_LPAR);
                    if (!inq)
                        depth++;
                end
                3: begin
                    if (inq || depth > 0) begin
                        put_byte(CH_RPAR);
                        if (!inq)
                            depth--;
                    end
                end
                default: put_byte(pick("azAZ09${}-_./*@:=[]+<>"));
            endcase
        end
        // an open quote toggle is sometimes left on so whitespace ends the argument
        if (inq && $urandom_range(0, 9) < 7) begin
            put_byte(CH_QUOTE);
            inq = 1'b0;
        end
        if (!inq)
            repeat (depth) put_byte(CH_RPAR);
    endfunction

    function automatic void put_command();
        int n;
        put_name();
        if ($urandom_range(0, 2) == 0)
            put_ws(1'b0);
        put_byte(CH_LPAR);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            if (i > 0 || $urandom_range(0, 1) == 1) begin
                if ($urandom_range(0, 4) == 0)
                    put_comment();
                else
                    put_ws(1'b0);
            end
            if ($urandom_range(0, 2) == 0)
                put_quoted();
            else
                put_unquoted();
        end
        if ($urandom_range(0, 1) == 1)
            put_ws(1'b0);
        put_byte(CH_RPAR);
    endfunction

    function automatic void put_top_item();
        case ($urandom_range(0, 3))
            0:       put_ws(1'b1);
            1:       put_comment();
            default: put_command();
        endcase
    endfunction

    function automatic void build_directed();
        script_q.delete();
        put_byte("a");
        put_req(FN_END, 8'hFF);
        put_byte(8'hFF);
        put_byte("x");
        put_req(FN_END, 8'h00);
        put_byte(8'h00);
        put_end();
        // end inside a quoted argument with an escape pending
        put_byte("f");
        put_byte(CH_SPACE);
        put_byte(CH_LPAR);
        put_byte(CH_QUOTE);
        put_byte(CH_BSLASH);
        put_end();
        put_byte("g");
        put_byte(CH_LPAR);
        put_byte("a");
        put_end();
        put_byte("h");
        put_byte("!");
        put_end();
        put_byte("i");
        put_byte(CH_LPAR);
        put_byte("!");
        put_end();
        put_byte(CH_HASH);
        put_byte("x");
        put_end();
    endfunction

    function automatic void build_random(int target);
        int r;
        script_q.delete();
        live_count = 0;
        while (live_count < target) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                repeat ($urandom_range(1, 3)) put_top_item();
            end else if (r < 75) begin
                if ($urandom_range(0, 1) == 1)
                    put_top_item();
                put_name();
                if ($urandom_range(0, 1) == 1)
                    put_byte(CH_LPAR);
                put_byte(8'($urandom_range(0, 255)));
                put_ws(1'b1);
                put_byte(pick("a(#)"));
            end else if (r < 90) begin
                // stream cut short at various points of a command
                put_name();
                case ($urandom_range(0, 4))
                    0: ;
                    1: put_ws(1'b0);
                    2: begin
                        put_byte(CH_LPAR);
                        put_byte(CH_QUOTE);
                        put_byte("q");
                        if ($urandom_range(0, 1) == 1)
                            put_byte(CH_BSLASH);
                    end
                    3: begin
                        put_byte(CH_LPAR);
                        put_unquoted();
                    end
                    default: begin
                        put_byte(CH_LPAR);
                        put_byte(CH_HASH);
                        put_byte("z");
                    end
                endcase
            end else begin
                repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
            end
            put_end();
        end
    endfunction

    function automatic void build_overflow();
        script_q.delete();
        put_byte("n");
        put_byte(CH_LPAR);
        put_byte("a");
        repeat (NEST_MAX + 1) put_byte(CH_LPAR);
        put_byte(CH_RPAR);
        put_end();
    endfunction

    task automatic send_script();
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 12);
        for (int i = 0; i < script_q.size(); i++) begin
            s_tvalid <= 1'b1;
            s_tdata  <= script_q[i].ch;
            s_tuser  <= script_q[i].func;
            do @(posedge aclk); while (!s_tready);
            tracker.note_request(script_q[i].func, script_q[i].ch);
            sent_count++;
            if (script_q[i].func == FN_END)
                end_count++;
            burst_left--;
            if (i == script_q.size() - 1) begin
                s_tvalid <= 1'b0;
            end else if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
                // keep offering while the receiver holds off
                gap = rx_hold ? 0 : $urandom_range(0, 4);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    task automatic wait_drain();
        while (tracker.pending_tags.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = FN_BYTE;
        m_tready    = 1'b0;
        cycle_count = 0;
        rx_cycle    = 0;
        rx_mode     = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        rx_hold     = 1'b0;
        sent_count  = 0;
        end_count   = 0;
        tracker     = new();
        gen_model   = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        build_directed();
        send_script();
        wait_drain();
        build_random(RANDOM_ITEMS / 2);
        send_script();
        wait_drain();
        build_overflow();
        send_script();
        wait_drain();
        build_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        send_script();
        wait_drain();
        repeat (8) @(posedge aclk);

        if (tracker.pending_tags.size() != 0) begin
            $display("%0d expected results never arrived", tracker.pending_tags.size());
            tracker.mismatches += tracker.pending_tags.size();
        end
        $display("sent %0d requests (%0d end markers), checked %0d results, %0d mismatches",
                 sent_count, end_count, tracker.checked, tracker.mismatches);
        $display("error codes reached, bit n for code n: %b", tracker.codes_seen[8:0]);
        if (tracker.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
